/* rtl/edf_three_class_scheduler_defines.svh */
// Assertion macros shared by the scheduler RTL.
// In synthesis builds every macro expands to nothing.
`ifndef EDF_THREE_CLASS_SCHEDULER_DEFINES_SVH
`define EDF_THREE_CLASS_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked only outside reset.
`define EDF3_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define EDF3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define EDF3_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define EDF3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/edf3_pkg.sv */
package edf3_pkg;

    // Number of job classes and their encoding.
    localparam int NumClasses = 3;

    typedef logic [1:0]  cls_t;
    typedef logic [47:0] time_t;
    typedef logic [31:0] word_t;

    localparam cls_t CLS_IDLE = 2'd3;
    localparam time_t TIME_MAX = 48'hFFFF_FFFF_FFFF;

    typedef logic [NumClasses-1:0][47:0] dl_arr_t;
    typedef logic [NumClasses-1:0][31:0] word_arr_t;

    // Input operation carried on s_tuser.
    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_ARRIVE = 1'b1
    } op_t;

    // Configuration register indexes.
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_REL_A    = 3'd0;
    localparam cfg_idx_t CFG_REL_B    = 3'd1;
    localparam cfg_idx_t CFG_REL_C    = 3'd2;
    localparam cfg_idx_t CFG_BUDGET_A = 3'd3;
    localparam cfg_idx_t CFG_BUDGET_B = 3'd4;
    localparam cfg_idx_t CFG_BUDGET_C = 3'd5;

    // Reset values of the configuration registers.
    localparam word_t REL_A_RST    = 32'd2000;
    localparam word_t REL_B_RST    = 32'd3000;
    localparam word_t REL_C_RST    = 32'd300;
    localparam word_t BUDGET_A_RST = 32'd500;
    localparam word_t BUDGET_B_RST = 32'd1000;
    localparam word_t BUDGET_C_RST = 32'd200;

    // Earliest deadline among classes with work left; lower index wins a tie.
    function automatic cls_t pick_runner(input logic [NumClasses-1:0] live,
                                         input dl_arr_t dl);
        cls_t  best;
        time_t best_dl;
        best    = CLS_IDLE;
        best_dl = '0;
        for (int k = 0; k < NumClasses; k++) begin
            if (live[k] && (best == CLS_IDLE || dl[k] < best_dl)) begin
                best    = cls_t'(k);
                best_dl = dl[k];
            end
        end
        return best;
    endfunction

endpackage

/* rtl/edf_three_class_scheduler.sv */
// Channel   Direction  Handshake              Payload
// s_*       in         s_tvalid / s_tready    s_tdata: job_class; s_tuser: op
// m_*       out        m_tvalid / m_tready    m_tdata: one result word
// cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Every input word is processed in the cycle it is accepted; its result is
// registered and shown on m_* from the next cycle, one result per input.
// Sustained rate is one word per cycle; the only limit is the result register.
// s_tready drops only while a result waits and m_tready is low.
// Reset clears the scheduler state and loads the default deadlines and budgets.
// cfg_ready is always high; configuration is written only while idle is a rule for the user, not enforced by the block.
`include "edf_three_class_scheduler_defines.svh"

module edf_three_class_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [1:0] job_class
    input  logic [0:0]  s_tuser,    // [0] op
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [1:0] running, [2] started,
                                    // [4:3] started_class, [36:5] start_count,
                                    // [37] finished, [39:38] finished_class
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Configuration registers.
    edf3_pkg::word_arr_t rel_reg;
    edf3_pkg::word_arr_t budget_reg;

    // Scheduler state.
    edf3_pkg::time_t     now_reg,     now_next;
    edf3_pkg::dl_arr_t   dl_reg,      dl_next;
    edf3_pkg::word_arr_t work_reg,    work_next;
    logic [2:0]          pend_reg,    pend_next;
    edf3_pkg::word_arr_t starts_reg,  starts_next;
    edf3_pkg::cls_t      cur_reg,     cur_next;

    // Result register.
    logic                m_tvalid_reg, m_tvalid_next;
    logic [39:0]         m_tdata_reg,  m_tdata_next;

    logic                in_accept;
    edf3_pkg::cls_t      in_cls;
    logic [48:0]         dl_sum;
    logic [2:0]          live;
    logic                res_started;
    edf3_pkg::cls_t      res_started_cls;
    edf3_pkg::word_t     res_count;
    logic                res_finished;
    edf3_pkg::cls_t      res_finished_cls;
    edf3_pkg::word_t     work_dec;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign in_cls    = s_tdata[1:0];
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Configuration register writes; indexes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rel_reg[0]    <= edf3_pkg::REL_A_RST;
            rel_reg[1]    <= edf3_pkg::REL_B_RST;
            rel_reg[2]    <= edf3_pkg::REL_C_RST;
            budget_reg[0] <= edf3_pkg::BUDGET_A_RST;
            budget_reg[1] <= edf3_pkg::BUDGET_B_RST;
            budget_reg[2] <= edf3_pkg::BUDGET_C_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                edf3_pkg::CFG_REL_A:    rel_reg[0]    <= cfg_data;
                edf3_pkg::CFG_REL_B:    rel_reg[1]    <= cfg_data;
                edf3_pkg::CFG_REL_C:    rel_reg[2]    <= cfg_data;
                edf3_pkg::CFG_BUDGET_A: budget_reg[0] <= cfg_data;
                edf3_pkg::CFG_BUDGET_B: budget_reg[1] <= cfg_data;
                edf3_pkg::CFG_BUDGET_C: budget_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Arrival and tick processing for the accepted word.
    always_comb begin
        now_next         = now_reg;
        dl_next          = dl_reg;
        work_next        = work_reg;
        pend_next        = pend_reg;
        starts_next      = starts_reg;
        cur_next         = cur_reg;
        res_started      = 1'b0;
        res_started_cls  = '0;
        res_count        = '0;
        res_finished     = 1'b0;
        res_finished_cls = '0;
        dl_sum           = '0;
        live             = '0;
        work_dec         = '0;

        if (in_accept) begin
            if (s_tuser[0] == edf3_pkg::OP_ARRIVE) begin
                // New job: saturating deadline, full budget, pending start.
                if (in_cls != edf3_pkg::CLS_IDLE) begin
                    dl_sum = {1'b0, now_reg} + {17'b0, rel_reg[in_cls]};
                    dl_next[in_cls]   = dl_sum[48] ? edf3_pkg::TIME_MAX : dl_sum[47:0];
                    work_next[in_cls] = budget_reg[in_cls];
                    pend_next[in_cls] = 1'b1;
                end
                for (int k = 0; k < edf3_pkg::NumClasses; k++) begin
                    live[k] = (work_next[k] != '0);
                end
                cur_next = edf3_pkg::pick_runner(live, dl_next);
            end else if (cur_reg != edf3_pkg::CLS_IDLE) begin
                // One tick of the running class.
                if (pend_reg[cur_reg]) begin
                    pend_next[cur_reg]   = 1'b0;
                    starts_next[cur_reg] = starts_reg[cur_reg] + 32'd1;
                    res_started          = 1'b1;
                    res_started_cls      = cur_reg;
                    res_count            = starts_reg[cur_reg] + 32'd1;
                end
                if (now_reg != edf3_pkg::TIME_MAX) begin
                    now_next = now_reg + 48'd1;
                end
                work_dec = (work_reg[cur_reg] != '0) ? work_reg[cur_reg] - 32'd1 : '0;
                work_next[cur_reg] = work_dec;
                if (work_dec == '0) begin
                    res_finished     = 1'b1;
                    res_finished_cls = cur_reg;
                    for (int k = 0; k < edf3_pkg::NumClasses; k++) begin
                        live[k] = (work_next[k] != '0);
                    end
                    cur_next = edf3_pkg::pick_runner(live, dl_reg);
                end
            end
        end
    end

    // Result register: loads on accept, empties when taken.
    always_comb begin
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        if (in_accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {res_finished_cls, res_finished, res_count,
                             res_started_cls, res_started, cur_next};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // State and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg      <= '0;
            dl_reg       <= '0;
            work_reg     <= '0;
            pend_reg     <= '0;
            starts_reg   <= '0;
            cur_reg      <= edf3_pkg::CLS_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            now_reg      <= now_next;
            dl_reg       <= dl_next;
            work_reg     <= work_next;
            pend_reg     <= pend_next;
            starts_reg   <= starts_next;
            cur_reg      <= cur_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    // The selected runner always has work left.
    `EDF3_ASSERT_IMPL(a_runner_has_work, aclk, aresetn, cur_reg != edf3_pkg::CLS_IDLE, (cur_reg == 2'd0 && work_reg[0] != '0) || (cur_reg == 2'd1 && work_reg[1] != '0) || (cur_reg == 2'd2 && work_reg[2] != '0), "runner has no work left")

    // A tick while idle leaves time where it was.
    `EDF3_ASSERT_NEXT(a_idle_tick_holds_time, aclk, aresetn, in_accept && s_tuser[0] == edf3_pkg::OP_TICK && cur_reg == edf3_pkg::CLS_IDLE, $stable(now_reg), "time moved on an idle tick")

    // Time never runs backwards.
    `EDF3_ASSERT_NEXT(a_time_monotonic, aclk, aresetn, 1'b1, now_reg >= $past(now_reg), "time decreased")

endmodule
